// ===== design/iir_halfband_decimator_2x_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the halfband decimator
// Concurrent assertion forms used by the decimator top level, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef IIR_HALFBAND_DECIMATOR_2X_ASSERT_SVH
`define IIR_HALFBAND_DECIMATOR_2X_ASSERT_SVH

// Same-cycle implication.
`define IHD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihd: same-cycle check failed");

// Next-cycle implication.
`define IHD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihd: next-cycle check failed");

`endif

// ===== design/ihd_pkg.sv =====
// ---------------------------------------------------------------------------
// Halfband decimator package
// Sequencer states, the control word to the section unit and the allpass
// coefficients in Q0.18.
// ---------------------------------------------------------------------------
package ihd_pkg;

  localparam int NUM_SECT = 4;
  localparam int SECT_BITS = 2;
  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_LAST = 4'b1111;
  // Accumulate step of section 2 on the even sample: the average is formed here.
  localparam logic [STEP_BITS-1:0] STEP_OUT = 4'b0101;

  localparam int COEF_Q_BITS = 18;
  localparam logic [NUM_SECT-1:0][COEF_Q_BITS-1:0] COEF_Q18 = {
    18'd218736, 18'd74404, 18'd142961, 18'd20937
  };

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic                 en;
    logic                 acc;
    logic [SECT_BITS-1:0] sec;
  } ctl_t;

endpackage

// ===== design/iir_halfband_decimator_2x.sv =====
// The result enters the output register at the averaging step of the item's sequence.
// Eight allpass updates per item, each a multiply step and then a round, add and
// saturate step, run on the single shared section unit.
// A new item is taken in the last cycle of the previous one; a result still held
// at the output stalls the sequencer at the averaging step.
// Reset is synchronous, active low, and clears all filter history.
// ---------------------------------------------------------------------------
// Halfband 2:1 IIR decimator
// Two cascaded allpass branches per sample pair, averaged and saturated; one
// filtered sample out per pair of input samples.
// ---------------------------------------------------------------------------
module iir_halfband_decimator_2x #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample_even, sample_odd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // sample_out
);
  import ihd_pkg::*;

`include "iir_halfband_decimator_2x_assert.svh"

  state_t                        state_r, state_nxt;
  logic [STEP_BITS-1:0]          cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] even_r;
  logic signed [SAMPLE_BITS-1:0] odd_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_valid_r;

  logic                          in_acc;
  logic                          out_step;
  logic                          stall;
  ctl_t                          ctl;
  logic signed [SAMPLE_BITS-1:0] x_sel;
  logic signed [SAMPLE_BITS-1:0] avg;

  assign in_acc   = in_tvalid && in_tready;
  assign out_step = (state_r == ST_RUN) && (cnt_r == STEP_OUT);
  assign stall    = out_step && out_valid_r && !out_tready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_r == STEP_LAST) begin
          cnt_nxt = '0;
          if (!in_acc) begin
            state_nxt = ST_IDLE;
          end
        end else if (!stall) begin
          cnt_nxt = cnt_r + STEP_BITS'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctl.en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_RUN: begin
        in_tready = (cnt_r == STEP_LAST);
        ctl.en    = !stall;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    ctl.acc = cnt_r[0];
    ctl.sec = cnt_r[2:1];
  end

  assign x_sel = cnt_r[3] ? odd_r : even_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_step && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      even_r <= in_tdata[SAMPLE_BITS-1:0];
      odd_r  <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (out_step && !stall) begin
      out_sample_r <= avg;
    end
  end

  ihd_section_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_sect (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .x_in   (x_sel),
    .avg_out(avg)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'($unsigned(out_sample_r));

  `IHD_ASSERT_IMP(a_ready_only_at_end, (state_r == ST_RUN) && in_tready, cnt_r == STEP_LAST)
  `IHD_ASSERT_NXT(a_stall_holds_step, stall, (state_r == ST_RUN) && (cnt_r == STEP_OUT))
  `IHD_ASSERT_NXT(a_accept_starts, in_acc, (state_r == ST_RUN) && (cnt_r == '0))
  `IHD_ASSERT_IMP(a_out_step_even, out_step, !cnt_r[3] && cnt_r[0])

endmodule

// ===== design/ihd_section_unit.sv =====
// ---------------------------------------------------------------------------
// Shared allpass section unit
// One multiplier and one round, add and saturate path, time-shared by the
// four allpass sections, with their history and the branch output registers.
// ---------------------------------------------------------------------------
module ihd_section_unit #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ihd_pkg::ctl_t                 ctl,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic signed [SAMPLE_BITS-1:0] avg_out
);
  import ihd_pkg::*;

  localparam int IW = SAMPLE_BITS + 2;
  localparam int DW = IW + 1;
  localparam int PW = DW + COEF_BITS + 1;
  localparam int SW = IW + 2;
  localparam int UP = (COEF_BITS >= COEF_Q_BITS) ? COEF_BITS - COEF_Q_BITS : 0;
  localparam int DN = (COEF_BITS < COEF_Q_BITS) ? COEF_Q_BITS - COEF_BITS : 0;
  localparam logic [63:0] RND = (DN > 0) ? (64'd1 << (DN - 1)) : 64'd0;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (COEF_BITS - 1);
  localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic [COEF_BITS-1:0] coef_of(input logic [SECT_BITS-1:0] idx);
    logic [63:0] c;
    c = 64'(COEF_Q18[idx]);
    c = ((c << UP) + RND) >> DN;
    return c[COEF_BITS-1:0];
  endfunction

  logic signed [IW-1:0] xh1_r [NUM_SECT];
  logic signed [IW-1:0] xh2_r [NUM_SECT];
  logic signed [IW-1:0] yh1_r [NUM_SECT];
  logic signed [IW-1:0] yh2_r [NUM_SECT];
  logic signed [IW-1:0] prev_y_r;
  logic signed [IW-1:0] a_r;
  logic signed [IW-1:0] bdel_r;
  logic signed [PW-1:0] prod_r;

  logic signed [IW-1:0]        sec_in;
  logic signed [DW-1:0]        diff;
  logic signed [COEF_BITS:0]   coef_s;
  logic signed [PW-1:0]        prod_nxt;
  logic signed [PW-1:0]        rnd_full;
  logic signed [SW-1:0]        sum;
  logic signed [IW-1:0]        y_sat;
  logic signed [IW:0]          avg_sum;
  logic signed [IW-1:0]        avg_sh;

  assign sec_in = ctl.sec[0] ? prev_y_r : {{2{x_in[SAMPLE_BITS-1]}}, x_in};
  assign diff = {sec_in[IW-1], sec_in} - {yh2_r[ctl.sec][IW-1], yh2_r[ctl.sec]};
  assign coef_s = {1'b0, coef_of(ctl.sec)};
  assign prod_nxt = diff * coef_s;

  assign rnd_full = (prod_r + HALF) >>> COEF_BITS;
  assign sum = {rnd_full[DW-1], rnd_full[DW-1:0]}
             + {{2{xh2_r[ctl.sec][IW-1]}}, xh2_r[ctl.sec]};

  always_comb begin
    if ((&sum[SW-1:IW-1]) || !(|sum[SW-1:IW-1])) begin
      y_sat = sum[IW-1:0];
    end else if (sum[SW-1]) begin
      y_sat = INT_MIN;
    end else begin
      y_sat = INT_MAX;
    end
  end

  assign avg_sum = {a_r[IW-1], a_r} + {bdel_r[IW-1], bdel_r} + (IW+1)'(1);
  assign avg_sh = avg_sum[IW:1];

  always_comb begin
    if ((&avg_sh[IW-1:SAMPLE_BITS-1]) || !(|avg_sh[IW-1:SAMPLE_BITS-1])) begin
      avg_out = avg_sh[SAMPLE_BITS-1:0];
    end else if (avg_sh[IW-1]) begin
      avg_out = OUT_MIN;
    end else begin
      avg_out = OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && !ctl.acc) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SECT; i++) begin
        xh1_r[i] <= '0;
        xh2_r[i] <= '0;
        yh1_r[i] <= '0;
        yh2_r[i] <= '0;
      end
      prev_y_r <= '0;
      a_r      <= '0;
      bdel_r   <= '0;
    end else if (ctl.en && ctl.acc) begin
      xh2_r[ctl.sec] <= xh1_r[ctl.sec];
      xh1_r[ctl.sec] <= sec_in;
      yh2_r[ctl.sec] <= yh1_r[ctl.sec];
      yh1_r[ctl.sec] <= y_sat;
      prev_y_r       <= y_sat;
      if (ctl.sec == SECT_BITS'(1)) begin
        a_r <= y_sat;
      end
      if (ctl.sec == SECT_BITS'(3)) begin
        bdel_r <= y_sat;
      end
    end
  end

endmodule
